// ===== hdl/led_matrix_command_engine_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LED_MATRIX_COMMAND_ENGINE_MACROS_SVH
`define LED_MATRIX_COMMAND_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmce assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmce assertion failed");

`endif

// ===== hdl/lmce_pkg.sv =====
`default_nettype none

package lmce_pkg;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic [7:0] value;
  } lmce_in_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } lmce_out_t;

  typedef enum logic [2:0] {
    ACT_PIXEL,
    ACT_ROW,
    ACT_COLUMN,
    ACT_CLEAR,
    ACT_INTENSITY,
    ACT_INIT
  } action_t;

  typedef enum logic [1:0] {OP_KEEP, OP_SET_BIT, OP_LOAD, OP_ZERO} row_op_t;
  typedef enum logic {RSEL_INPUT, RSEL_COUNT} row_sel_t;
  typedef enum logic {BSEL_NONZERO, BSEL_VALUE_BIT} bit_sel_t;
  typedef enum logic [1:0] {DSEL_ROW, DSEL_VALUE, DSEL_CONST} data_sel_t;
  typedef enum logic {ASEL_ROW, ASEL_CONST} addr_sel_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_END} seq_t;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_NONE       = 4'd0;
  localparam upc_t UPC_PIXEL      = 4'd1;
  localparam upc_t UPC_ROW        = 4'd2;
  localparam upc_t UPC_COLUMN     = 4'd3;
  localparam upc_t UPC_CLEAR      = 4'd4;
  localparam upc_t UPC_INTENSITY  = 4'd5;
  localparam upc_t UPC_INIT       = 4'd6;
  localparam upc_t UPC_INIT_SCAN  = 4'd7;
  localparam upc_t UPC_INIT_LEVEL = 4'd8;
  localparam upc_t UPC_INIT_TEST  = 4'd9;
  localparam upc_t UPC_INIT_LAST  = 4'd10;

  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [3:0] ADDR_TEST      = 4'hF;

  localparam logic [7:0] MAX_LEVEL      = 8'd15;
  localparam logic [2:0] ROW_LAST       = 3'd7;

  // One control word of the sequencer program.
  typedef struct packed {
    row_op_t    op;
    row_sel_t   rsel;
    bit_sel_t   bsel;
    data_sel_t  dsel;
    addr_sel_t  asel;
    logic [3:0] caddr;
    logic [7:0] cdata;
    seq_t       seq;
  } ucw_t;

  // Control from the sequencer to the datapath for the current step.
  typedef struct packed {
    logic       fire;
    row_op_t    op;
    logic [2:0] row;
    logic [2:0] col;
    logic       bit_on;
    data_sel_t  dsel;
    addr_sel_t  asel;
    logic [3:0] caddr;
    logic [7:0] cdata;
    logic [7:0] value;
    logic       last;
  } lmce_ctl_t;

  function automatic ucw_t ucode(upc_t pc);
    ucw_t w;
    w = '{op: OP_KEEP, rsel: RSEL_INPUT, bsel: BSEL_NONZERO, dsel: DSEL_ROW,
          asel: ASEL_ROW, caddr: 4'h0, cdata: 8'h00, seq: SEQ_END};
    case (pc)
      UPC_PIXEL: begin
        w.op = OP_SET_BIT;
      end
      UPC_ROW: begin
        w.op = OP_LOAD;
      end
      UPC_COLUMN: begin
        w.op   = OP_SET_BIT;
        w.rsel = RSEL_COUNT;
        w.bsel = BSEL_VALUE_BIT;
        w.seq  = SEQ_LOOP;
      end
      UPC_CLEAR: begin
        w.op   = OP_ZERO;
        w.rsel = RSEL_COUNT;
        w.seq  = SEQ_LOOP;
      end
      UPC_INTENSITY: begin
        w.dsel  = DSEL_VALUE;
        w.asel  = ASEL_CONST;
        w.caddr = ADDR_INTENSITY;
      end
      UPC_INIT: begin
        w.dsel = DSEL_CONST; w.asel = ASEL_CONST;
        w.caddr = ADDR_DECODE; w.cdata = 8'h00; w.seq = SEQ_NEXT;
      end
      UPC_INIT_SCAN: begin
        w.dsel = DSEL_CONST; w.asel = ASEL_CONST;
        w.caddr = ADDR_SCANLIMIT; w.cdata = 8'h07; w.seq = SEQ_NEXT;
      end
      UPC_INIT_LEVEL: begin
        w.dsel = DSEL_CONST; w.asel = ASEL_CONST;
        w.caddr = ADDR_INTENSITY; w.cdata = 8'h0F; w.seq = SEQ_NEXT;
      end
      UPC_INIT_TEST: begin
        w.dsel = DSEL_CONST; w.asel = ASEL_CONST;
        w.caddr = ADDR_TEST; w.cdata = 8'h00; w.seq = SEQ_NEXT;
      end
      UPC_INIT_LAST: begin
        w.dsel = DSEL_CONST; w.asel = ASEL_CONST;
        w.caddr = ADDR_SHUTDOWN; w.cdata = 8'h01;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Start address of the program for a command, or none if it writes nothing.
  function automatic upc_t entry_point(lmce_in_t w);
    upc_t pc;
    pc = UPC_NONE;
    case (w.action)
      ACT_PIXEL:     pc = (w.row_index[3] || w.column_index[3]) ? UPC_NONE : UPC_PIXEL;
      ACT_ROW:       pc = w.row_index[3] ? UPC_NONE : UPC_ROW;
      ACT_COLUMN:    pc = w.column_index[3] ? UPC_NONE : UPC_COLUMN;
      ACT_CLEAR:     pc = UPC_CLEAR;
      ACT_INTENSITY: pc = (w.value > MAX_LEVEL) ? UPC_NONE : UPC_INTENSITY;
      ACT_INIT:      pc = UPC_INIT;
      default:       pc = UPC_NONE;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lmce_seq.sv =====
`default_nettype none

module lmce_seq
  import lmce_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lmce_in_t  in_word,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_free,
  output lmce_ctl_t      ctl
);

  logic       busy_r, busy_nxt;
  upc_t       upc_r, upc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  lmce_in_t   cmd_r, cmd_nxt;
  ucw_t       ucw;
  logic       fire;
  logic       cnt_done;
  upc_t       entry;

  assign ucw      = ucode(upc_r);
  assign fire     = busy_r && out_free;
  assign cnt_done = (cnt_r == ROW_LAST);
  assign entry    = entry_point(in_word);
  assign in_ready = !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    cnt_nxt  = cnt_r;
    cmd_nxt  = cmd_r;
    if (in_valid && in_ready) begin
      cmd_nxt  = in_word;
      upc_nxt  = entry;
      busy_nxt = (entry != UPC_NONE);
      cnt_nxt  = '0;
    end else if (fire) begin
      case (ucw.seq)
        SEQ_NEXT: begin
          upc_nxt = upc_r + 4'd1;
        end
        SEQ_LOOP: begin
          if (cnt_done) begin
            busy_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_NONE;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_comb begin
    ctl.fire   = fire;
    ctl.op     = ucw.op;
    ctl.row    = (ucw.rsel == RSEL_COUNT) ? cnt_r : cmd_r.row_index[2:0];
    ctl.col    = cmd_r.column_index[2:0];
    ctl.bit_on = (ucw.bsel == BSEL_VALUE_BIT) ? cmd_r.value[cnt_r] : (|cmd_r.value);
    ctl.dsel   = ucw.dsel;
    ctl.asel   = ucw.asel;
    ctl.caddr  = ucw.caddr;
    ctl.cdata  = ucw.cdata;
    ctl.value  = cmd_r.value;
    ctl.last   = (ucw.seq == SEQ_END) || ((ucw.seq == SEQ_LOOP) && cnt_done);
  end

endmodule

`default_nettype wire

// ===== hdl/lmce_datapath.sv =====
`default_nettype none

module lmce_datapath
  import lmce_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lmce_ctl_t ctl,
  output logic           out_free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lmce_out_t      out_word
);

  logic [7:0] rows_r [8];
  logic [7:0] rows_nxt [8];
  logic       out_valid_r, out_valid_nxt;
  lmce_out_t  out_word_r, out_word_nxt;
  logic [7:0] cur_row;
  logic [7:0] new_row;
  logic [7:0] mask;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    cur_row = rows_r[ctl.row];
    mask    = 8'd1 << ctl.col;
    case (ctl.op)
      OP_SET_BIT: new_row = ctl.bit_on ? (cur_row | mask) : (cur_row & ~mask);
      OP_LOAD:    new_row = ctl.value;
      OP_ZERO:    new_row = 8'h00;
      default:    new_row = cur_row;
    endcase

    rows_nxt = rows_r;
    if (ctl.fire) begin
      rows_nxt[ctl.row] = new_row;
    end

    out_word_nxt = out_word_r;
    if (ctl.fire) begin
      out_word_nxt.reg_addr = (ctl.asel == ASEL_CONST) ? ctl.caddr
                                                       : ({1'b0, ctl.row} + 4'd1);
      case (ctl.dsel)
        DSEL_VALUE: out_word_nxt.reg_data = ctl.value;
        DSEL_CONST: out_word_nxt.reg_data = ctl.cdata;
        default:    out_word_nxt.reg_data = new_row;
      endcase
      out_word_nxt.last = ctl.last;
    end

    out_valid_nxt = ctl.fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= '{default: 8'h00};
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/led_matrix_command_engine.sv =====
// Channel   Direction  Word         Handshake
// in_       input      lmce_in_t    in_valid / in_ready
// out_      output     lmce_out_t   out_valid / out_ready
//
// A command is taken while in_valid and in_ready are both high, then the sequencer steps once per register write.
// Pixel, row and intensity commands give one write, init five, column and clear eight.
// A command that writes nothing never makes the sequencer busy, so in_ready stays high.
// A stalled output holds the sequencer; a new command is taken once the last write
// of the previous one is in the output register. Reset is synchronous and clears the frame.
`default_nettype none

module led_matrix_command_engine
  import lmce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lmce_in_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lmce_out_t     out_word
);

  lmce_ctl_t ctl;
  logic      out_free;

  lmce_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .ctl      (ctl)
  );

  lmce_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== hdl/lmce_checker.sv =====
`default_nettype none
`include "led_matrix_command_engine_macros.svh"

module lmce_checker
  import lmce_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire lmce_in_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire lmce_out_t out_word
);

  logic in_stall;
  logic out_stall;
  logic addr_known;
  logic level_write;
  logic level_ok;

  assign in_stall    = in_valid && !in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign addr_known  = out_word.reg_addr inside {[4'h1:4'h8], ADDR_DECODE, ADDR_INTENSITY,
                                                 ADDR_SCANLIMIT, ADDR_SHUTDOWN, ADDR_TEST};
  assign level_write = out_valid && (out_word.reg_addr == ADDR_INTENSITY);
  assign level_ok    = (out_word.reg_data[7:4] == 4'h0);

  `LMCE_ASSERT_NXT(a_in_hold, clk, rst_n, in_stall, in_valid && $stable(in_word))
  `LMCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))
  `LMCE_ASSERT_IMP(a_addr_known, clk, rst_n, out_valid, addr_known)
  `LMCE_ASSERT_IMP(a_busy_mid_cmd, clk, rst_n, out_valid && !out_word.last, !in_ready)
  `LMCE_ASSERT_IMP(a_level_range, clk, rst_n, level_write, level_ok)

endmodule

bind led_matrix_command_engine lmce_checker u_lmce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
